FILE: rtl/apf_pkg.sv
// shared constants for the articulation point finder
package apf_pkg;

    localparam int VW               = 6;
    localparam int NVW              = 7;
    localparam int TW               = 7;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

endpackage

FILE: rtl/articulation_point_finder_core.sv
// articulation point finder: edge load, list build, iterative dfs and ordered report
// flow: edges load one per cycle while the core is idle; after the final item: clear of the vertex
// tables, two list passes over the stored edges with the offsets built between them, an iterative
// search (root checks, vertex entries, list entries, returns) and a report over the vertices;
// one graph at a time: a new graph's edges are taken only after its last result is loaded
// reset: num_vertices returns to 64, edge count and overflow clear; rams are not cleared
module articulation_point_finder_core #(
    parameter int MAX_VERTICES = apf_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = apf_pkg::DEF_MAX_EDGES
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [apf_pkg::NVW-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [apf_pkg::VW-1:0]  edge_from,
    input  logic [apf_pkg::VW-1:0]  edge_to,
    input  logic                    edge_present,
    input  logic                    last_edge,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [apf_pkg::VW-1:0]  cut_vertex,
    output logic                    none_found,
    output logic                    edge_overflow,
    output logic                    last_result
);

    import apf_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int NL  = 2 * MAX_EDGES;
    localparam int NAW = $clog2(NL);
    localparam int PW  = $clog2(NL + 1);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int OAW = $clog2(MAX_VERTICES + 1);
    localparam int DW  = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic [VW-1:0] node;
        logic [VW-1:0] par;
        logic          hasp;
        logic [PW-1:0] pos;
        logic [PW-1:0] last;
        logic [TW-1:0] kids;
        logic [TW-1:0] entry;
        logic [TW-1:0] low;
    } frame_t;

    localparam int FW = $bits(frame_t);

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_CLR      = 22'h000002,
        S_EDGE_RD  = 22'h000004,
        S_EDGE_WT  = 22'h000008,
        S_A_WT     = 22'h000010,
        S_B_RD     = 22'h000020,
        S_B_WT     = 22'h000040,
        S_PFX_RD   = 22'h000080,
        S_PFX_WT   = 22'h000100,
        S_ROOT_RD  = 22'h000200,
        S_ROOT_WT  = 22'h000400,
        S_OFF0     = 22'h000800,
        S_OFF1     = 22'h001000,
        S_ENTER    = 22'h002000,
        S_STEP     = 22'h004000,
        S_NBR_WT   = 22'h008000,
        S_VIS_WT   = 22'h010000,
        S_POP_WT   = 22'h020000,
        S_EMIT_RD  = 22'h040000,
        S_EMIT_WT  = 22'h080000,
        S_EMIT_OUT = 22'h100000,
        S_FIN      = 22'h200000
    } state_t;

    state_t         state_reg, state_next;
    logic [NVW-1:0] cfg_nv_reg, cfg_nv_next;
    logic [NVW-1:0] nv_reg, nv_next;
    logic [ETW-1:0] total_reg, total_next;
    logic           ovf_reg, ovf_next;
    logic [ETW-1:0] e_reg, e_next;
    logic [NVW-1:0] i_reg, i_next;
    logic           pass_reg, pass_next;
    logic [VW-1:0]  a_reg, a_next;
    logic [VW-1:0]  b_reg, b_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [TW-1:0]  time_reg, time_next;
    logic [DW-1:0]  depth_reg, depth_next;
    frame_t         top_reg, top_next;
    logic [VW-1:0]  nw_reg, nw_next;
    logic           nhasp_reg, nhasp_next;
    logic [PW-1:0]  off0_reg, off0_next;
    logic           pend_reg, pend_next;
    logic [VW-1:0]  pend_v_reg, pend_v_next;
    logic           ov_reg, ov_next;
    logic [VW-1:0]  ocut_reg, ocut_next;
    logic           onone_reg, onone_next;
    logic           oovf_reg, oovf_next;
    logic           olast_reg, olast_next;

    logic             edge_we;
    logic [2*VW-1:0]  edge_rd;
    logic             cnt_we;
    logic [VAW-1:0]   cnt_wa, cnt_ra;
    logic [PW-1:0]    cnt_wd, cnt_rd;
    logic             off_we;
    logic [OAW-1:0]   off_wa, off_ra;
    logic [PW-1:0]    off_wd, off_rd;
    logic             nbr_we;
    logic [NAW-1:0]   nbr_wa, nbr_ra;
    logic [VW-1:0]    nbr_wd, nbr_rd;
    logic             vtx_we;
    logic [VAW-1:0]   vtx_wa, vtx_ra;
    logic [TW:0]      vtx_wd, vtx_rd;
    logic             cut_we;
    logic [VAW-1:0]   cut_wa, cut_ra;
    logic             cut_wd, cut_rd;
    logic             stk_we;
    logic [VAW-1:0]   stk_wa, stk_ra;
    logic [FW-1:0]    stk_rd;
    frame_t           stk_frame;
    logic             out_free;
    logic [VW-1:0]    ea, eb;
    logic [DW-1:0]    depth_m1, depth_m2;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign cut_vertex    = ocut_reg;
    assign none_found    = onone_reg;
    assign edge_overflow = oovf_reg;
    assign last_result   = olast_reg;
    assign out_free      = !ov_reg || out_ready;
    assign stk_frame     = frame_t'(stk_rd);
    assign ea            = edge_rd[2*VW-1:VW];
    assign eb            = edge_rd[VW-1:0];
    assign depth_m1      = depth_reg - DW'(1);
    assign depth_m2      = depth_reg - DW'(2);
    assign edge_we       = (state_reg == S_IDLE) && in_valid && edge_present
                           && (total_reg < ETW'(MAX_EDGES));

    apf_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(total_reg[EAW-1:0]), .wdata({edge_from, edge_to}),
        .raddr(e_reg[EAW-1:0]), .rdata(edge_rd)
    );

    apf_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
        .raddr(cnt_ra), .rdata(cnt_rd)
    );

    apf_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES + 1)) u_off_ram (
        .clk(clk), .we(off_we), .waddr(off_wa), .wdata(off_wd),
        .raddr(off_ra), .rdata(off_rd)
    );

    apf_ram #(.WIDTH(VW), .DEPTH(NL)) u_nbr_ram (
        .clk(clk), .we(nbr_we), .waddr(nbr_wa), .wdata(nbr_wd),
        .raddr(nbr_ra), .rdata(nbr_rd)
    );

    apf_ram #(.WIDTH(TW + 1), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .clk(clk), .we(vtx_we), .waddr(vtx_wa), .wdata(vtx_wd),
        .raddr(vtx_ra), .rdata(vtx_rd)
    );

    apf_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_cut_ram (
        .clk(clk), .we(cut_we), .waddr(cut_wa), .wdata(cut_wd),
        .raddr(cut_ra), .rdata(cut_rd)
    );

    apf_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(FW'(top_reg)),
        .raddr(stk_ra), .rdata(stk_rd)
    );

    always_comb
    begin
        state_next  = state_reg;
        cfg_nv_next = cfg_we ? cfg_data : cfg_nv_reg;
        nv_next     = nv_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        e_next      = e_reg;
        i_next      = i_reg;
        pass_next   = pass_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        time_next   = time_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        nw_next     = nw_reg;
        nhasp_next  = nhasp_reg;
        off0_next   = off0_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        ov_next     = ov_reg && !out_ready;
        ocut_next   = ocut_reg;
        onone_next  = onone_reg;
        oovf_next   = oovf_reg;
        olast_next  = olast_reg;

        cnt_we = 1'b0;
        cnt_wa = a_reg[VAW-1:0];
        cnt_wd = cnt_rd + PW'(1);
        cnt_ra = a_reg[VAW-1:0];
        off_we = 1'b0;
        off_wa = i_reg[OAW-1:0];
        off_wd = acc_reg;
        off_ra = OAW'({1'b0, nw_reg});
        nbr_we = 1'b0;
        nbr_wa = cnt_rd[NAW-1:0];
        nbr_wd = b_reg;
        nbr_ra = top_reg.pos[NAW-1:0];
        vtx_we = 1'b0;
        vtx_wa = i_reg[VAW-1:0];
        vtx_wd = '0;
        vtx_ra = i_reg[VAW-1:0];
        cut_we = 1'b0;
        cut_wa = i_reg[VAW-1:0];
        cut_wd = 1'b0;
        cut_ra = i_reg[VAW-1:0];
        stk_we = 1'b0;
        stk_wa = depth_m1[VAW-1:0];
        stk_ra = depth_m2[VAW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (edge_present)
                    begin
                        if (total_reg < ETW'(MAX_EDGES))
                        begin
                            total_next = total_reg + ETW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (last_edge)
                    begin
                        nv_next    = (cfg_nv_reg > NVW'(MAX_VERTICES)) ? NVW'(MAX_VERTICES)
                                                                       : cfg_nv_reg;
                        i_next     = '0;
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                if (i_reg == nv_reg)
                begin
                    e_next     = '0;
                    pass_next  = 1'b0;
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    cnt_we = 1'b1;
                    cnt_wa = i_reg[VAW-1:0];
                    cnt_wd = '0;
                    vtx_we = 1'b1;
                    cut_we = 1'b1;
                    i_next = i_reg + NVW'(1);
                end
            end
            S_EDGE_RD:
            begin
                if (e_reg == total_reg)
                begin
                    i_next = '0;
                    if (!pass_reg)
                    begin
                        acc_next   = '0;
                        state_next = S_PFX_RD;
                    end
                    else
                    begin
                        time_next  = TW'(1);
                        state_next = S_ROOT_RD;
                    end
                end
                else
                begin
                    state_next = S_EDGE_WT;
                end
            end
            S_EDGE_WT:
            begin
                a_next = ea;
                b_next = eb;
                cnt_ra = ea[VAW-1:0];
                if (({1'b0, ea} < nv_reg) && ({1'b0, eb} < nv_reg))
                begin
                    state_next = S_A_WT;
                end
                else
                begin
                    e_next     = e_reg + ETW'(1);
                    state_next = S_EDGE_RD;
                end
            end
            S_A_WT:
            begin
                cnt_we     = 1'b1;
                nbr_we     = pass_reg;
                state_next = S_B_RD;
            end
            S_B_RD:
            begin
                cnt_ra     = b_reg[VAW-1:0];
                state_next = S_B_WT;
            end
            S_B_WT:
            begin
                cnt_we     = 1'b1;
                cnt_wa     = b_reg[VAW-1:0];
                nbr_we     = pass_reg;
                nbr_wd     = a_reg;
                e_next     = e_reg + ETW'(1);
                state_next = S_EDGE_RD;
            end
            S_PFX_RD:
            begin
                cnt_ra = i_reg[VAW-1:0];
                if (i_reg == nv_reg)
                begin
                    off_we     = 1'b1;
                    e_next     = '0;
                    pass_next  = 1'b1;
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    state_next = S_PFX_WT;
                end
            end
            S_PFX_WT:
            begin
                off_we     = 1'b1;
                cnt_we     = 1'b1;
                cnt_wa     = i_reg[VAW-1:0];
                cnt_wd     = acc_reg;
                acc_next   = acc_reg + cnt_rd;
                i_next     = i_reg + NVW'(1);
                state_next = S_PFX_RD;
            end
            S_ROOT_RD:
            begin
                if (i_reg == nv_reg)
                begin
                    i_next     = '0;
                    pend_next  = 1'b0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_ROOT_WT;
                end
            end
            S_ROOT_WT:
            begin
                if (vtx_rd[TW])
                begin
                    i_next     = i_reg + NVW'(1);
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    nw_next    = i_reg[VW-1:0];
                    nhasp_next = 1'b0;
                    depth_next = '0;
                    state_next = S_OFF0;
                end
            end
            S_OFF0:
            begin
                state_next = S_OFF1;
            end
            S_OFF1:
            begin
                off_ra     = OAW'({1'b0, nw_reg} + NVW'(1));
                off0_next  = off_rd;
                state_next = S_ENTER;
            end
            S_ENTER:
            begin
                vtx_we = 1'b1;
                vtx_wa = nw_reg[VAW-1:0];
                vtx_wd = {1'b1, time_reg};
                stk_we = (depth_reg != '0);
                top_next.node  = nw_reg;
                top_next.par   = nhasp_reg ? top_reg.node : '0;
                top_next.hasp  = nhasp_reg;
                top_next.pos   = off0_reg;
                top_next.last  = off_rd;
                top_next.kids  = '0;
                top_next.entry = time_reg;
                top_next.low   = time_reg;
                depth_next = depth_reg + DW'(1);
                time_next  = time_reg + TW'(1);
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (top_reg.pos < top_reg.last)
                begin
                    top_next.pos = top_reg.pos + PW'(1);
                    state_next   = S_NBR_WT;
                end
                else if (depth_reg == DW'(1))
                begin
                    cut_we     = (top_reg.kids > TW'(1));
                    cut_wa     = top_reg.node[VAW-1:0];
                    cut_wd     = 1'b1;
                    depth_next = '0;
                    i_next     = i_reg + NVW'(1);
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    state_next = S_POP_WT;
                end
            end
            S_NBR_WT:
            begin
                nw_next = nbr_rd;
                vtx_ra  = nbr_rd[VAW-1:0];
                if (top_reg.hasp && (nbr_rd == top_reg.par))
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_VIS_WT;
                end
            end
            S_VIS_WT:
            begin
                if (!vtx_rd[TW])
                begin
                    top_next.kids = top_reg.kids + TW'(1);
                    nhasp_next    = 1'b1;
                    state_next    = S_OFF0;
                end
                else
                begin
                    if (vtx_rd[TW-1:0] < top_reg.low)
                    begin
                        top_next.low = vtx_rd[TW-1:0];
                    end
                    state_next = S_STEP;
                end
            end
            S_POP_WT:
            begin
                top_next = stk_frame;
                if (top_reg.low < stk_frame.low)
                begin
                    top_next.low = top_reg.low;
                end
                cut_we     = (top_reg.low >= stk_frame.entry) && stk_frame.hasp;
                cut_wa     = stk_frame.node[VAW-1:0];
                cut_wd     = 1'b1;
                depth_next = depth_m1;
                state_next = S_STEP;
            end
            S_EMIT_RD:
            begin
                state_next = (i_reg == nv_reg) ? S_FIN : S_EMIT_WT;
            end
            S_EMIT_WT:
            begin
                if (cut_rd && pend_reg)
                begin
                    state_next = S_EMIT_OUT;
                end
                else
                begin
                    if (cut_rd)
                    begin
                        pend_next   = 1'b1;
                        pend_v_next = i_reg[VW-1:0];
                    end
                    i_next     = i_reg + NVW'(1);
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    ocut_next   = pend_v_reg;
                    onone_next  = 1'b0;
                    oovf_next   = ovf_reg;
                    olast_next  = 1'b0;
                    pend_v_next = i_reg[VW-1:0];
                    i_next      = i_reg + NVW'(1);
                    state_next  = S_EMIT_RD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ocut_next  = pend_reg ? pend_v_reg : '0;
                    onone_next = !pend_reg;
                    oovf_next  = ovf_reg;
                    olast_next = 1'b1;
                    total_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cfg_nv_reg <= NVW'(64);
            nv_reg     <= '0;
            total_reg  <= '0;
            ovf_reg    <= 1'b0;
            e_reg      <= '0;
            i_reg      <= '0;
            pass_reg   <= 1'b0;
            time_reg   <= TW'(1);
            depth_reg  <= '0;
            nhasp_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cfg_nv_reg <= cfg_nv_next;
            nv_reg     <= nv_next;
            total_reg  <= total_next;
            ovf_reg    <= ovf_next;
            e_reg      <= e_next;
            i_reg      <= i_next;
            pass_reg   <= pass_next;
            time_reg   <= time_next;
            depth_reg  <= depth_next;
            nhasp_reg  <= nhasp_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        top_reg    <= top_next;
        nw_reg     <= nw_next;
        off0_reg   <= off0_next;
        pend_v_reg <= pend_v_next;
        ocut_reg   <= ocut_next;
        onone_reg  <= onone_next;
        oovf_reg   <= oovf_next;
        olast_reg  <= olast_next;
    end

endmodule

FILE: rtl/apf_ram.sv
// generic single write port ram with registered read
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/tb_top.sv
// testbench for the articulation point finder: edge stimulus, cut vertex prediction, checking
`timescale 1ns / 1ps

module tb_top;

    import apf_pkg::*;

    localparam int NV_MAX  = DEF_MAX_VERTICES;
    localparam int NE_MAX  = DEF_MAX_EDGES;
    localparam int CYC_MAX = 3000000;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic          none;
        logic          ovf;
        logic          last;
    } cut_rec_t;

    typedef struct packed {
        logic [VW-1:0] from;
        logic [VW-1:0] to;
        logic          present;
        logic          last;
    } edge_item_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [NVW-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [VW-1:0] edge_from;
    logic [VW-1:0] edge_to;
    logic edge_present;
    logic last_edge;
    logic out_valid;
    logic out_ready;
    logic [VW-1:0] cut_vertex;
    logic none_found;
    logic edge_overflow;
    logic last_result;

    articulation_point_finder_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .edge_from    (edge_from),
        .edge_to      (edge_to),
        .edge_present (edge_present),
        .last_edge    (last_edge),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cut_vertex   (cut_vertex),
        .none_found   (none_found),
        .edge_overflow(edge_overflow),
        .last_result  (last_result)
    );

    // predictor state
    int unsigned  vcount;
    logic [11:0]  stored_edges[NE_MAX];
    int unsigned  stored_cnt;
    bit           dropped;
    cut_rec_t     cut_queue[$];
    int           errors;
    longint       cycles;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYC_MAX)
            begin
                $display("articulation_point_finder_core: mismatch");
                $finish;
            end
        end
    end

    function automatic void find_cuts();
        int unsigned nv;
        int unsigned deg[NV_MAX+1];
        int unsigned off[NV_MAX+1];
        int unsigned fill[NV_MAX];
        int unsigned adj[2*NE_MAX];
        bit          seen[NV_MAX];
        bit          cut[NV_MAX];
        int unsigned tin[NV_MAX];
        int unsigned tlow[NV_MAX];
        int unsigned st_node[NV_MAX];
        int unsigned st_par[NV_MAX];
        bit          st_haspar[NV_MAX];
        int unsigned st_pos[NV_MAX];
        int unsigned st_kids[NV_MAX];
        int unsigned depth, clock_t, a, b, v, w, p, n;
        cut_rec_t    r;
        nv = (vcount > NV_MAX) ? NV_MAX : vcount;
        for (int i = 0; i <= NV_MAX; i++) deg[i] = 0;
        for (int i = 0; i < stored_cnt; i++)
        begin
            a = stored_edges[i][11:6];
            b = stored_edges[i][5:0];
            if (a < nv && b < nv)
            begin
                deg[a]++;
                deg[b]++;
            end
        end
        off[0] = 0;
        for (int i = 0; i < nv; i++)
        begin
            off[i+1] = off[i] + deg[i];
            fill[i] = off[i];
        end
        for (int i = 0; i < stored_cnt; i++)
        begin
            a = stored_edges[i][11:6];
            b = stored_edges[i][5:0];
            if (a < nv && b < nv)
            begin
                adj[fill[a]++] = b;
                adj[fill[b]++] = a;
            end
        end
        for (int i = 0; i < NV_MAX; i++)
        begin
            seen[i] = 0;
            cut[i] = 0;
        end
        clock_t = 1;
        for (int root = 0; root < nv; root++)
        begin
            if (seen[root]) continue;
            depth = 0;
            seen[root] = 1;
            tin[root] = clock_t;
            tlow[root] = clock_t;
            clock_t = (clock_t + 1) & 127;
            st_node[0] = root;
            st_haspar[0] = 0;
            st_par[0] = 0;
            st_pos[0] = off[root];
            st_kids[0] = 0;
            depth = 1;
            while (depth > 0)
            begin
                v = st_node[depth-1];
                if (st_pos[depth-1] < off[v+1])
                begin
                    w = adj[st_pos[depth-1]];
                    st_pos[depth-1]++;
                    if (st_haspar[depth-1] && w == st_par[depth-1]) continue;
                    if (!seen[w])
                    begin
                        st_kids[depth-1]++;
                        seen[w] = 1;
                        tin[w] = clock_t;
                        tlow[w] = clock_t;
                        clock_t = (clock_t + 1) & 127;
                        if (depth < NV_MAX)
                        begin
                            st_node[depth] = w;
                            st_par[depth] = v;
                            st_haspar[depth] = 1;
                            st_pos[depth] = off[w];
                            st_kids[depth] = 0;
                            depth++;
                        end
                    end
                    else if (tin[w] < tlow[v])
                        tlow[v] = tin[w];
                end
                else
                begin
                    depth--;
                    if (st_haspar[depth])
                    begin
                        p = st_par[depth];
                        if (tlow[v] < tlow[p]) tlow[p] = tlow[v];
                        if (tlow[v] >= tin[p] && depth > 0 && st_haspar[depth-1])
                            cut[p] = 1;
                    end
                    else if (st_kids[depth] > 1)
                        cut[v] = 1;
                end
            end
        end
        n = 0;
        for (int i = 0; i < nv; i++)
            if (cut[i])
            begin
                r.vertex = i[VW-1:0];
                r.none = 1'b0;
                r.ovf = dropped;
                r.last = 1'b0;
                cut_queue.insert(cut_queue.size(), r);
                n++;
            end
        if (n == 0)
        begin
            r.vertex = '0;
            r.none = 1'b1;
            r.ovf = dropped;
            r.last = 1'b1;
            cut_queue.insert(cut_queue.size(), r);
        end
        else
            cut_queue[$].last = 1'b1;
        stored_cnt = 0;
        dropped = 0;
    endfunction

    function automatic void take_edge(edge_item_t it);
        if (it.present)
        begin
            if (stored_cnt < NE_MAX) stored_edges[stored_cnt++] = {it.from, it.to};
            else dropped = 1;
        end
        if (it.last) find_cuts();
    endfunction

    // result side
    initial begin
        int       stall;
        cut_rec_t exp_r;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (cut_queue.size() == 0)
            begin
                $error("unexpected result cut_vertex=%0d", cut_vertex);
                errors++;
            end
            else
            begin
                exp_r = cut_queue.pop_front();
                if (cut_vertex !== exp_r.vertex)
                begin
                    $error("cut_vertex exp %0d got %0d", exp_r.vertex, cut_vertex);
                    errors++;
                end
                if (none_found !== exp_r.none)
                begin
                    $error("none_found exp %0d got %0d", exp_r.none, none_found);
                    errors++;
                end
                if (edge_overflow !== exp_r.ovf)
                begin
                    $error("edge_overflow exp %0d got %0d", exp_r.ovf, edge_overflow);
                    errors++;
                end
                if (last_result !== exp_r.last)
                begin
                    $error("last_result exp %0d got %0d", exp_r.last, last_result);
                    errors++;
                end
            end
        end
    end

    task automatic send_edge(edge_item_t it);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        in_valid     <= 1'b1;
        edge_from    <= it.from;
        edge_to      <= it.to;
        edge_present <= it.present;
        last_edge    <= it.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        take_edge(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cut_queue.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vcount(logic [NVW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        vcount = val;
    endtask

    function automatic edge_item_t mk(int f, int t, int p, int l);
        edge_item_t it;
        it.from = f[VW-1:0];
        it.to = t[VW-1:0];
        it.present = p[0];
        it.last = l[0];
        return it;
    endfunction

    // one random graph, vertex numbers limited to 0..span so that structure appears
    task automatic rand_graph(int nedges, int span);
        for (int i = 0; i < nedges; i++)
            send_edge(mk($urandom_range(0, span), $urandom_range(0, span),
                         int'($urandom_range(0, 9) != 0), 0));
        send_edge(mk($urandom_range(0, span), $urandom_range(0, span),
                     int'($urandom_range(0, 1)), 1));
    endtask

    edge_item_t directed[] = '{
        mk(0, 0, 0, 1),
        mk(0, 1, 1, 0), mk(1, 2, 1, 1),
        mk(0, 1, 1, 0), mk(1, 2, 1, 0), mk(2, 0, 1, 0), mk(3, 3, 1, 0),
        mk(2, 3, 1, 0), mk(2, 3, 1, 1),
        mk(63, 62, 1, 0), mk(62, 61, 1, 0), mk(0, 63, 1, 1),
        mk(5, 6, 1, 0), mk(6, 7, 1, 0), mk(7, 8, 1, 0), mk(8, 5, 1, 0),
        mk(8, 9, 1, 0), mk(9, 10, 1, 0), mk(10, 9, 1, 0), mk(42, 21, 0, 1)
    };

    initial begin
        errors = 0;
        vcount = 64;
        stored_cnt = 0;
        dropped = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        edge_from = '0;
        edge_to = '0;
        edge_present = 1'b0;
        last_edge = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_edge(directed[i]);
        drain();

        // capacity overflow at the extreme vertex count
        write_vcount(7'd127);
        for (int i = 0; i < NE_MAX + 2; i++)
            send_edge(mk(i % 64, (i + 1) % 64, 1, 0));
        send_edge(mk(0, 0, 1, 1));
        drain();

        write_vcount(7'd0);
        send_edge(mk(0, 1, 1, 0));
        send_edge(mk(1, 2, 1, 1));
        drain();

        write_vcount(7'd1);
        send_edge(mk(0, 0, 1, 0));
        send_edge(mk(0, 1, 1, 1));
        drain();

        for (int g = 0; g < 12; g++)
        begin
            if (g % 8 == 0)
            begin
                drain();
                write_vcount($urandom_range(0, 1) ? 7'($urandom_range(2, 16))
                                                  : 7'($urandom_range(0, 127)));
            end
            rand_graph($urandom_range(0, 14), $urandom_range(3, 63));
        end

        drain();
        write_vcount(7'd64);
        rand_graph(30, 63);
        rand_graph(12, 15);

        drain();
        if (errors == 0)
            $display("articulation_point_finder_core: match");
        else
            $display("articulation_point_finder_core: mismatch");
        $finish;
    end

endmodule
